// ===== hw/rtl/sil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// shared constants and types for the sorted insertion list
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take the input beat and register the compare mask
        logic commit;   // apply the insert and load the result register
    } sil_cmd_t;

endpackage

// ===== hw/rtl/sorted_insert_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list
// bounded ascending list of unsigned 32-bit values filled by insertion
// ----------------------------------------------------------------------------
// a result beat is registered by the shift-insert step, which follows the
//   compare step on the accepted input beat; the next input beat is taken only
//   after that commit, since each insert needs the list left by the last
// while a result waits, one more input beat is taken and compared, then the
//   input side stalls until the waiting result is taken
// reset: asynchronous, active low; clears the internal entry count and the handshakes,
//   list cells and result registers hold no reset value; cells are read only below the count
// ----------------------------------------------------------------------------
module sorted_insert_list
    import sil_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel: one value per beat
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [VALUE_W-1:0] new_value,
    // result channel: one beat per input beat
    output logic               result_valid,
    input  logic               result_stall,
    output logic [SLOT_W-1:0]  slot,
    output logic [COUNT_W-1:0] entry_count,
    output logic               rejected_full
);

    sil_cmd_t cmd;

    // controller: sequences capture (compare) and commit (shift-insert)
    sil_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // datapath: list cells, parallel compare mask, count and result register
    //  - a new value lands after any equal entries already stored
    //  - when the list is full the value is dropped, slot reads 0 and the
    //    flag is raised with the unchanged count
    sil_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .new_value     (new_value),
        .slot          (slot),
        .entry_count   (entry_count),
        .rejected_full (rejected_full)
    );

endmodule

// ===== hw/rtl/sil_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_ctrl
// two-state controller: accept a beat, then commit it into the list
// ----------------------------------------------------------------------------
module sil_ctrl
    import sil_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output sil_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_INSERT = 1'b1;

    logic state_reg;
    logic state_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic can_load;

    assign can_load     = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                // hold the insert until the result register has room
                if (can_load)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ===== hw/rtl/sil_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_datapath
// row of list cells with per-cell compare and shift-insert, plus result regs
// ----------------------------------------------------------------------------
module sil_datapath
    import sil_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sil_cmd_t           cmd,
    input  logic [VALUE_W-1:0] new_value,
    output logic [SLOT_W-1:0]  slot,
    output logic [COUNT_W-1:0] entry_count,
    output logic               rejected_full
);

    logic [VALUE_W-1:0] cells_reg [CAPACITY];
    logic [CAPACITY-1:0] le_reg;
    logic [CAPACITY-1:0] le_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAPACITY-1:0] first_gt;
    logic [IDX_W-1:0]    pos;
    logic                full;
    logic                do_insert;
    logic [SLOT_W-1:0]   slot_reg;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic                rejected_reg;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_insert = cmd.commit && !full;

    // valid entries not above the new value; a prefix since the list is sorted
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le_next[i] = (CNT_W'(i) < count_reg) && (cells_reg[i] <= new_value);
        end
    end

    // insertion point: the first cell outside the prefix
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                first_gt[i] = !le_reg[i];
            end
            else
            begin
                first_gt[i] = !le_reg[i] && le_reg[i-1];
            end
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos = pos | (first_gt[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    assign count_next = do_insert ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= new_value;
            le_reg    <= le_next;
        end
        if (cmd.commit)
        begin
            slot_reg        <= full ? SLOT_W'(0) : SLOT_W'(pos);
            entry_count_reg <= COUNT_W'(count_next);
            rejected_reg    <= full;
        end
    end

    // each cell keeps, takes the new value, or takes its lower neighbor
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (do_insert && !le_reg[g])
            begin
                if (g == 0)
                begin
                    cells_reg[g] <= value_reg;
                end
                else if (le_reg[(g == 0) ? 0 : g - 1])
                begin
                    cells_reg[g] <= value_reg;
                end
                else
                begin
                    cells_reg[g] <= cells_reg[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    assign slot          = slot_reg;
    assign entry_count   = entry_count_reg;
    assign rejected_full = rejected_reg;

endmodule
